[sv/msfsc_pkg.sv]
// Package for the multi-stream frame set collector.
// Holds the table size, request/response structs, register indexes and sequencer states.
// No dependencies.
package msfsc_pkg;

   // table size and stream id width
   localparam int MAX_STREAMS     = 8;
   localparam int STREAM_ID_WIDTH = 4;
   localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int CNT_W = $clog2(MAX_STREAMS + 1);

   // configuration port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STREAM_COUNT = 1'b0,
      CSR_AGE_LIMIT    = 1'b1
   } csr_index_type;

   // one frame descriptor request
   typedef struct packed {
      logic [STREAM_ID_WIDTH-1:0] stream_id;
      logic [30:0]                frame_number;
      logic [63:0]                capture_time_us;
      logic [7:0]                 source_type;
   } req_type;

   // one emitted entry of a frame set
   typedef struct packed {
      logic [STREAM_ID_WIDTH-1:0] out_stream_id;
      logic [30:0]                out_frame_number;
      logic [63:0]                out_capture_time_us;
      logic [7:0]                 out_source_type;
      logic                       last_in_set;
   } rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_EMIT
   } state_type;

endpackage

[sv/multi_stream_frame_set_collector.sv]
// Top level of the multi-stream frame set collector: pending table, scan sequencer,
// shared age comparator and set emission. Depends on msfsc_pkg.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// request is fully handled. The sequencer walks the P pending entries one per cycle
// through a single 64-bit age comparator that also checks for a repeated stream id and
// compacts the table in place, then appends the new descriptor in its own state. If the
// table then holds the configured stream count, its N entries are sent one per cycle
// on rsp_data with rsp_valid high for one cycle each, the last one flagged, and the table
// is cleared. Busy then drops and the next request can be taken. At most seven
// entries are pending between requests. Responses cannot be held off: the receiver must
// take each one in the cycle it is shown. Configuration writes are meant to happen only
// while busy is low.
module multi_stream_frame_set_collector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  msfsc_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output msfsc_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [msfsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [msfsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // sequencer and control registers
   msfsc_pkg::state_type             state_ff, state_in;
   logic [msfsc_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [msfsc_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [msfsc_pkg::CNT_W-1:0]      kept_ff, kept_in;
   logic                             same_ff, same_in;
   logic [3:0]                       stream_count_ff;
   logic [31:0]                      age_limit_ff;

   // payload registers
   msfsc_pkg::req_type               req_ff, req_in;
   msfsc_pkg::req_type               entry_ff [msfsc_pkg::MAX_STREAMS];

   // table write port
   logic                             ent_we;
   logic [msfsc_pkg::IDX_W-1:0]      ent_waddr;
   msfsc_pkg::req_type               ent_wdata;

   // derived values
   msfsc_pkg::req_type               cur_entry;
   logic [64:0]                      age_diff;
   logic                             too_old;
   logic                             id_match;
   logic                             scan_done;
   logic [msfsc_pkg::CNT_W-1:0]      need;
   logic [msfsc_pkg::CNT_W-1:0]      base;
   logic [msfsc_pkg::CNT_W-1:0]      new_count;
   logic                             set_full;
   logic                             emit_last;
   msfsc_pkg::csr_index_type         csr_sel;

   assign csr_sel = msfsc_pkg::csr_index_type'(csr_index);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_count_ff <= 4'd1;
         age_limit_ff    <= 32'd20000;
      end else if (csr_we) begin
         unique case (csr_sel)
            msfsc_pkg::CSR_STREAM_COUNT: stream_count_ff <= csr_wdata[3:0];
            msfsc_pkg::CSR_AGE_LIMIT:    age_limit_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // entries needed for a complete set: zero acts as one, large values saturate
   always_comb begin
      if (stream_count_ff == 4'd0) begin
         need = msfsc_pkg::CNT_W'(1);
      end else if (int'(stream_count_ff) > msfsc_pkg::MAX_STREAMS) begin
         need = msfsc_pkg::CNT_W'(msfsc_pkg::MAX_STREAMS);
      end else begin
         need = msfsc_pkg::CNT_W'(stream_count_ff);
      end
   end

   // shared compare unit: entry under the scan index against the held request
   assign cur_entry = entry_ff[idx_ff[msfsc_pkg::IDX_W-1:0]];
   assign age_diff  = {1'b0, req_ff.capture_time_us} - {1'b0, cur_entry.capture_time_us};
   assign too_old   = !age_diff[64] && (age_diff[63:0] > {32'd0, age_limit_ff});
   assign id_match  = (cur_entry.stream_id == req_ff.stream_id);
   assign scan_done = (idx_ff == count_ff);

   // append position and set completion
   assign base      = same_ff ? '0 : kept_ff;
   assign new_count = base + msfsc_pkg::CNT_W'(1);
   assign set_full  = (new_count >= need);
   assign emit_last = (idx_ff + msfsc_pkg::CNT_W'(1) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msfsc_pkg::ST_IDLE:   if (start) state_in = msfsc_pkg::ST_SCAN;
         msfsc_pkg::ST_SCAN:   if (scan_done) state_in = msfsc_pkg::ST_APPEND;
         msfsc_pkg::ST_APPEND: state_in = set_full ? msfsc_pkg::ST_EMIT : msfsc_pkg::ST_IDLE;
         msfsc_pkg::ST_EMIT:   if (emit_last) state_in = msfsc_pkg::ST_IDLE;
         default:              state_in = msfsc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != msfsc_pkg::ST_IDLE);
      rsp_valid = (state_ff == msfsc_pkg::ST_EMIT);
      rsp_data.out_stream_id       = cur_entry.stream_id;
      rsp_data.out_frame_number    = cur_entry.frame_number;
      rsp_data.out_capture_time_us = cur_entry.capture_time_us;
      rsp_data.out_source_type     = cur_entry.source_type;
      rsp_data.last_in_set         = emit_last;
   end

   // datapath next values and table writes
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      kept_in   = kept_ff;
      same_in   = same_ff;
      req_in    = req_ff;
      ent_we    = 1'b0;
      ent_waddr = kept_ff[msfsc_pkg::IDX_W-1:0];
      ent_wdata = cur_entry;
      unique case (state_ff)
         msfsc_pkg::ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               idx_in  = '0;
               kept_in = '0;
               same_in = 1'b0;
            end
         end
         msfsc_pkg::ST_SCAN: begin
            // repeated stream flushes everything; otherwise drop stale entries in order
            if (!scan_done) begin
               if (id_match) same_in = 1'b1;
               if (!too_old) begin
                  ent_we  = (kept_ff != idx_ff);
                  kept_in = kept_ff + msfsc_pkg::CNT_W'(1);
               end
               idx_in = idx_ff + msfsc_pkg::CNT_W'(1);
            end
         end
         msfsc_pkg::ST_APPEND: begin
            // at most MAX_STREAMS-1 entries survive, so the table never overflows here
            ent_we    = 1'b1;
            ent_waddr = base[msfsc_pkg::IDX_W-1:0];
            ent_wdata = req_ff;
            count_in  = new_count;
            idx_in    = '0;
         end
         msfsc_pkg::ST_EMIT: begin
            idx_in = idx_ff + msfsc_pkg::CNT_W'(1);
            if (emit_last) count_in = '0;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msfsc_pkg::ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         kept_ff  <= '0;
         same_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         kept_ff  <= kept_in;
         same_ff  <= same_in;
      end
   end

   // held request and pending table
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (ent_we) entry_ff[ent_waddr] <= ent_wdata;
   end

   // checks
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff < count_ff))
      else $error("response index beyond pending count");

   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_in_set) |=> (!busy && count_ff == '0))
      else $error("set did not end after last response");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not raise busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msfsc_pkg::ST_IDLE) |->
         (count_ff < msfsc_pkg::CNT_W'(msfsc_pkg::MAX_STREAMS)))
      else $error("pending table full while idle");

endmodule
